/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SSSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sssp_pkg.sv */
package sssp_pkg;

	// Default sizes
	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;

	// Fixed field widths
	localparam int VTX_W  = 4;
	localparam int CNT_W  = 5;
	localparam int DIST_W = 32;

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// Configuration register indexes
	localparam logic CFG_SOURCE_VERTEX = 1'b0;
	localparam logic CFG_VERTEX_COUNT  = 1'b1;

	// One distance memory word
	typedef struct packed {
		logic [VTX_W-1:0]         parent;
		logic signed [DIST_W-1:0] distance;
	} dist_entry_t;

endpackage

/* rtl/sssp_dist_ram.sv */
module sssp_dist_ram #(
	parameter int DEPTH  = sssp_pkg::MAX_VERTICES_DEF,
	parameter int ADDR_W = $clog2(sssp_pkg::MAX_VERTICES_DEF)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     wa,
	input  sssp_pkg::dist_entry_t wd,
	input  logic [ADDR_W-1:0]     ra_a,
	input  logic [ADDR_W-1:0]     ra_b,
	output sssp_pkg::dist_entry_t rd_a,
	output sssp_pkg::dist_entry_t rd_b
);

	sssp_pkg::dist_entry_t mem [DEPTH];

	// One write port, two registered read ports (read before write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[ra_a];
		rd_b <= mem[ra_b];
	end

endmodule

/* rtl/single_source_shortest_paths.sv */
// Single-source shortest paths over a directed graph held as an adjacency
// matrix. Edges arrive on the s_ channel, one transaction per cycle while
// loading; tuser is has_edge, tlast marks the final edge and starts the run.
// A later edge on the same (from, to) pair overwrites the earlier one.
// Configuration (source vertex, vertex count) must be written by the user on
// the cfg_ port while the block is idle; the block does not enforce this.
// Run: n-1 relaxation rounds plus one negative-cycle round, each visiting
// all n*n pairs, one pair per cycle through the edge and distance memories.
// Results then leave on the m_ channel, one per vertex in order; the next
// result is read only after the current one is taken. tlast marks the
// final vertex. A stalled receiver simply holds the result in the output
// register and the sequencer waits.
// After the last result, and after reset, the edge memory is swept clean,
// all MAX_VERTICES*MAX_VERTICES entries, one entry a cycle; s_tready is
// low then, and also for the whole run and result phase.
module single_source_shortest_paths #(
	parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF,
	localparam int IN_W  = ((2 * sssp_pkg::VTX_W + WEIGHT_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * sssp_pkg::VTX_W + sssp_pkg::DIST_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [sssp_pkg::CNT_W-1:0] cfg_wdata,
	// edges in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_W-1:0]            s_tdata,  // from_vertex, to_vertex, edge_weight
	input  logic                       s_tuser,  // has_edge
	input  logic                       s_tlast,  // last_edge
	// results out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_W-1:0]           m_tdata,  // vertex_index, distance, parent_vertex
	output logic [2:0]                 m_tuser,  // has_parent, reachable, negative_cycle
	output logic                       m_tlast   // last_result
);

	localparam int VW    = sssp_pkg::VTX_W;
	localparam int DW    = sssp_pkg::DIST_W;
	localparam int VIW   = $clog2(MAX_VERTICES);
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = DW + 2;

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_LOAD    = 8'b0000_0010,
		ST_INIT    = 8'b0000_0100,
		ST_RELAX   = 8'b0000_1000,
		ST_DRAIN   = 8'b0001_0000,
		ST_EMIT_RD = 8'b0010_0000,
		ST_EMIT_LD = 8'b0100_0000,
		ST_EMIT_WT = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [VW-1:0]    src_cfg_q;
	logic [sssp_pkg::CNT_W-1:0] cnt_cfg_q;
	logic [NW-1:0]    n_q;
	logic [VW-1:0]    src_q;
	logic [VIW-1:0]   iu_q, iv_q, ev_q;
	logic [NW-1:0]    rnd_q;
	logic             chk_q;
	logic [AW-1:0]    clr_q;
	logic [MAX_VERTICES-1:0] reached_q, pvalid_q;
	logic             neg_q;

	logic             vld_s1, chk_s1;
	logic [VIW-1:0]   u_s1, v_s1;

	logic             fwd_vld_q;
	logic [VIW-1:0]   fwd_addr_q;
	sssp_pkg::dist_entry_t fwd_data_q;

	logic [WEIGHT_BITS:0] edge_mem [DEPTH];
	logic [WEIGHT_BITS:0] edge_rd_s1;
	logic             edge_we;
	logic [AW-1:0]    edge_wa, edge_ra;
	logic [WEIGHT_BITS:0] edge_wd;

	logic [VW-1:0]    in_from, in_to;
	logic [WEIGHT_BITS-1:0] in_w;
	logic             in_ok, s_fire;
	logic [NW-1:0]    n_eff;
	logic [VIW-1:0]   nl;
	logic             src_in;

	logic             dist_we, relax_we;
	logic [VIW-1:0]   dist_wa;
	logic [VIW-1:0]   ra_a;
	sssp_pkg::dist_entry_t dist_wd, rd_a, rd_b;
	logic signed [DW-1:0] du, dv, sat_sum;
	logic signed [SW-1:0] sum;
	logic             improves;

	logic             out_valid_q, out_last_q, out_hp_q, out_rch_q, out_neg_q;
	logic [VW-1:0]    out_vtx_q, out_par_q;
	logic signed [DW-1:0] out_dist_q;

	// Input field unpacking
	assign in_from = s_tdata[VW-1:0];
	assign in_to   = s_tdata[2*VW-1:VW];
	assign in_w    = s_tdata[2*VW+WEIGHT_BITS-1:2*VW];
	assign in_ok   = (32'(in_from) < 32'(MAX_VERTICES)) && (32'(in_to) < 32'(MAX_VERTICES));
	assign s_tready = (state_q == ST_LOAD);
	assign s_fire   = s_tvalid && s_tready;

	// Vertex count clamped to 1 .. MAX_VERTICES
	always_comb begin
		if (cnt_cfg_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(cnt_cfg_q) > 32'(MAX_VERTICES)) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(cnt_cfg_q);
		end
	end
	assign nl = VIW'(n_q - NW'(1));

	// source lies among the vertices in use
	assign src_in = (32'(src_q) < 32'(n_q));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cfg_q <= '0;
			cnt_cfg_q <= sssp_pkg::CNT_W'(16);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sssp_pkg::CFG_SOURCE_VERTEX: src_cfg_q <= cfg_wdata[VW-1:0];
				sssp_pkg::CFG_VERTEX_COUNT:  cnt_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Edge memory: load writes, sweep clears, relaxation reads
	always_comb begin
		edge_we = 1'b0;
		edge_wa = AW'(32'(in_from) * MAX_VERTICES + 32'(in_to));
		edge_wd = {1'b1, in_w};
		if (state_q == ST_CLEAR) begin
			edge_we = 1'b1;
			edge_wa = clr_q;
			edge_wd = '0;
		end else if (s_fire && s_tuser && in_ok) begin
			edge_we = 1'b1;
		end
	end
	assign edge_ra = AW'(32'(iu_q) * MAX_VERTICES + 32'(iv_q));

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_s1 <= edge_mem[edge_ra];
	end

	// Distance and parent memory
	assign ra_a = (state_q == ST_EMIT_RD) ? ev_q : iu_q;

	sssp_dist_ram #(
		.DEPTH  (MAX_VERTICES),
		.ADDR_W (VIW)
	) u_dist_ram (
		.clk  (clk),
		.we   (dist_we),
		.wa   (dist_wa),
		.wd   (dist_wd),
		.ra_a (ra_a),
		.ra_b (iv_q),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	// Relaxation test on the pair read last cycle, with write forwarding
	always_comb begin
		du = (fwd_vld_q && fwd_addr_q == u_s1) ? fwd_data_q.distance : rd_a.distance;
		dv = (fwd_vld_q && fwd_addr_q == v_s1) ? fwd_data_q.distance : rd_b.distance;
		sum = SW'(du) + SW'($signed(edge_rd_s1[WEIGHT_BITS-1:0]));
		improves = vld_s1 && edge_rd_s1[WEIGHT_BITS] && reached_q[u_s1] &&
			(!reached_q[v_s1] || SW'(dv) > sum);
		if (sum > SW'(sssp_pkg::DIST_MAX)) begin
			sat_sum = sssp_pkg::DIST_MAX;
		end else if (sum < SW'(sssp_pkg::DIST_MIN)) begin
			sat_sum = sssp_pkg::DIST_MIN;
		end else begin
			sat_sum = DW'(sum);
		end
		relax_we = improves && !chk_s1;
		dist_we  = relax_we;
		dist_wa  = v_s1;
		dist_wd.distance = sat_sum;
		dist_wd.parent   = VW'(32'(u_s1));
		// the source starts the run at distance zero
		if (state_q == ST_INIT) begin
			dist_we = src_in;
			dist_wa = VIW'(32'(src_q));
			dist_wd = '0;
		end
	end

	// Pair pipeline stage and forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			vld_s1    <= (state_q == ST_RELAX);
			fwd_vld_q <= relax_we;
		end
	end

	always_ff @(posedge clk) begin
		u_s1       <= iu_q;
		v_s1       <= iv_q;
		chk_s1     <= chk_q;
		fwd_addr_q <= v_s1;
		fwd_data_q <= dist_wd;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			n_q       <= '0;
			src_q     <= '0;
			iu_q      <= '0;
			iv_q      <= '0;
			ev_q      <= '0;
			rnd_q     <= '0;
			chk_q     <= 1'b0;
			reached_q <= '0;
			pvalid_q  <= '0;
			neg_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// results of the relaxation test
			if (improves && chk_s1) begin
				neg_q <= 1'b1;
			end
			if (relax_we) begin
				reached_q[v_s1] <= 1'b1;
				pvalid_q[v_s1]  <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (s_fire && s_tlast) begin
						n_q     <= n_eff;
						src_q   <= src_cfg_q;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					reached_q <= src_in ? (MAX_VERTICES'(1) << src_q) : '0;
					pvalid_q  <= '0;
					neg_q   <= 1'b0;
					iu_q    <= '0;
					iv_q    <= '0;
					rnd_q   <= NW'(1);
					chk_q   <= (n_q == NW'(1));
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					if (iv_q == nl) begin
						iv_q <= '0;
						if (iu_q == nl) begin
							iu_q <= '0;
							if (chk_q) begin
								state_q <= ST_DRAIN;
							end else if (rnd_q == n_q - NW'(1)) begin
								chk_q <= 1'b1;
							end else begin
								rnd_q <= rnd_q + NW'(1);
							end
						end else begin
							iu_q <= iu_q + VIW'(1);
						end
					end else begin
						iv_q <= iv_q + VIW'(1);
					end
				end
				ST_DRAIN: begin
					ev_q    <= '0;
					state_q <= ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_WT;
				end
				ST_EMIT_WT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							ev_q    <= ev_q + VIW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_vtx_q  <= VW'(32'(ev_q));
			out_dist_q <= reached_q[ev_q] ? rd_a.distance : sssp_pkg::DIST_MAX;
			out_par_q  <= pvalid_q[ev_q] ? rd_a.parent : '0;
			out_hp_q   <= pvalid_q[ev_q];
			out_rch_q  <= reached_q[ev_q];
			out_neg_q  <= neg_q;
			out_last_q <= (ev_q == nl);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_par_q, out_dist_q, out_vtx_q});
	assign m_tuser  = {out_neg_q, out_rch_q, out_hp_q};
	assign m_tlast  = out_last_q;

endmodule

/* rtl/sssp_checker.sv */
`include "assert_macros.svh"

module sssp_checker #(
	parameter int OUT_W = 40
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [2:0]       m_tuser,
	input logic             m_tlast
);

	// A stalled result holds its payload
	`SSSP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// No edge is taken while a result is pending
	`SSSP_ASSERT_NOW(a_no_load_in_emit, clk, arst_n, m_tvalid, !s_tready, "edge accepted during result phase")

	// The final result is followed by an idle output and a low s_tready
	`SSSP_ASSERT_NEXT(a_last_ends, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid && !s_tready, "output or input active right after final result")

	// An unreachable vertex reports no parent
	`SSSP_ASSERT_NOW(a_unreached_no_parent, clk, arst_n, m_tvalid && !m_tuser[1], !m_tuser[0], "parent on unreachable vertex")

endmodule

bind single_source_shortest_paths sssp_checker #(.OUT_W($bits(m_tdata))) u_sssp_checker (.*);

/* bench/sssp_checker.sv */
// Watches the configuration port and both stream channels, predicts the result
// transactions of each graph run and compares them with what the block emits.
module sssp_scoreboard (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [sssp_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [23:0]                s_tdata,  // from_vertex, to_vertex, edge_weight
	input  logic                       s_tuser,  // has_edge
	input  logic                       s_tlast,  // last_edge
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [39:0]                m_tdata,  // vertex_index, distance, parent_vertex
	input  logic [2:0]                 m_tuser,  // has_parent, reachable, negative_cycle
	input  logic                       m_tlast,  // last_result
	output int                         mismatches,
	output int                         results_due,
	output int                         graphs_run,
	output int                         results_seen
);

	localparam int NV = 16;

	typedef struct packed {
		logic [3:0]         vertex;
		logic signed [31:0] distance;
		logic [3:0]         parent;
		logic               has_parent;
		logic               reachable;
		logic               neg_cycle;
		logic               last;
	} vertex_result_t;

	// graph and path state of the predictor
	logic signed [15:0] edge_w [NV*NV];
	bit                 edge_ok [NV*NV];
	longint             dist_now [NV];
	logic [3:0]         parent_of [NV];
	bit                 parent_ok [NV];
	bit                 seen [NV];
	logic [3:0]         src_vtx;
	logic [4:0]         vtx_cnt;
	vertex_result_t     path_results [$];

	assign results_due = path_results.size();

	// edge u->v shortens the path to v
	function automatic bit shortens(int u, int v, output longint sum);
		int k;
		k = u * NV + v;
		sum = 0;
		if (!edge_ok[k] || !seen[u]) return 0;
		sum = dist_now[u] + longint'(edge_w[k]);
		return !seen[v] || dist_now[v] > sum;
	endfunction

	// Bellman-Ford over the loaded graph, results queued per vertex
	function automatic void solve_paths();
		int n;
		bit neg;
		longint s;
		vertex_result_t r;
		n = vtx_cnt;
		if (n < 1) n = 1;
		if (n > NV) n = NV;
		neg = 0;
		for (int v = 0; v < NV; v++) begin
			dist_now[v] = 0;
			parent_of[v] = '0;
			parent_ok[v] = 0;
			seen[v] = 0;
		end
		if (src_vtx < n) begin
			seen[src_vtx] = 1;
			for (int rd = 1; rd < n; rd++)
				for (int u = 0; u < n; u++)
					for (int v = 0; v < n; v++)
						if (shortens(u, v, s)) begin
							if (s > 64'sd2147483647) s = 64'sd2147483647;
							if (s < -64'sd2147483648) s = -64'sd2147483648;
							dist_now[v] = s;
							parent_of[v] = u[3:0];
							parent_ok[v] = 1;
							seen[v] = 1;
						end
			for (int u = 0; u < n; u++)
				for (int v = 0; v < n; v++)
					if (shortens(u, v, s)) neg = 1;
		end
		for (int v = 0; v < n; v++) begin
			r.vertex = v[3:0];
			r.distance = seen[v] ? 32'(dist_now[v]) : sssp_pkg::DIST_MAX;
			r.parent = parent_ok[v] ? parent_of[v] : 4'd0;
			r.has_parent = parent_ok[v];
			r.reachable = seen[v];
			r.neg_cycle = neg;
			r.last = (v + 1 == n);
			path_results.push_back(r);
		end
		for (int k = 0; k < NV*NV; k++) edge_ok[k] = 0;
	endfunction

	// track configuration, edge and result transactions
	always_ff @(posedge clk or negedge arst_n) begin
		vertex_result_t e;
		if (!arst_n) begin
			src_vtx <= '0;
			vtx_cnt <= 5'd16;
			for (int k = 0; k < NV*NV; k++) edge_ok[k] = 0;
			path_results.delete();
			mismatches <= 0;
			graphs_run <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == sssp_pkg::CFG_SOURCE_VERTEX) src_vtx <= cfg_wdata[3:0];
				else vtx_cnt <= cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					edge_w[s_tdata[3:0] * NV + s_tdata[7:4]] = s_tdata[23:8];
					edge_ok[s_tdata[3:0] * NV + s_tdata[7:4]] = 1;
				end
				if (s_tlast) begin
					solve_paths();
					graphs_run <= graphs_run + 1;
				end
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (path_results.size() == 0) begin
					$error("result transaction with nothing expected: vertex %0d",
						m_tdata[3:0]);
					mismatches <= mismatches + 1;
				end else begin
					e = path_results.pop_front();
					if (m_tdata[3:0] !== e.vertex || m_tdata[35:4] !== e.distance ||
						m_tdata[39:36] !== e.parent || m_tuser[0] !== e.has_parent ||
						m_tuser[1] !== e.reachable || m_tuser[2] !== e.neg_cycle ||
						m_tlast !== e.last)
						mismatches <= mismatches + 1;
					if (m_tdata[3:0] !== e.vertex)
						$error("vertex_index expected %0d got %0d", e.vertex, m_tdata[3:0]);
					if (m_tdata[35:4] !== e.distance)
						$error("distance expected %0d got %0d", e.distance,
							$signed(m_tdata[35:4]));
					if (m_tdata[39:36] !== e.parent)
						$error("parent_vertex expected %0d got %0d", e.parent,
							m_tdata[39:36]);
					if (m_tuser[0] !== e.has_parent)
						$error("has_parent expected %0b got %0b", e.has_parent, m_tuser[0]);
					if (m_tuser[1] !== e.reachable)
						$error("reachable expected %0b got %0b", e.reachable, m_tuser[1]);
					if (m_tuser[2] !== e.neg_cycle)
						$error("negative_cycle expected %0b got %0b", e.neg_cycle,
							m_tuser[2]);
					if (m_tlast !== e.last)
						$error("last_result expected %0b got %0b", e.last, m_tlast);
				end
			end
		end
	end

endmodule

/* bench/tb_single_source_shortest_paths.sv */
module tb_single_source_shortest_paths;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_wr_en = 0;
	logic                       cfg_index = sssp_pkg::CFG_SOURCE_VERTEX;
	logic [sssp_pkg::CNT_W-1:0] cfg_wdata = '0;
	logic                       s_tvalid = 0;
	logic                       s_tready;
	logic [23:0]                s_tdata = '0;  // from_vertex, to_vertex, edge_weight
	logic                       s_tuser = 0;   // has_edge
	logic                       s_tlast = 0;   // last_edge
	logic                       m_tvalid;
	logic                       m_tready = 0;
	logic [39:0]                m_tdata;       // vertex_index, distance, parent_vertex
	logic [2:0]                 m_tuser;       // has_parent, reachable, negative_cycle
	logic                       m_tlast;       // last_result

	int mismatches, results_due, graphs_run, results_seen;
	int send_idle_pct = 34;
	int recv_idle_pct = 80;
	int hold_cycles = 0;
	logic hold_req = 0;
	int edges_sent = 0;

	always #2 clk = ~clk;

	single_source_shortest_paths u_top (.*);

	sssp_scoreboard u_chk (.*);

	// receiver: random back-pressure plus a long counted hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cycles <= 1500;
			m_tready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send_edge(int from_v, int to_v, int weight, bit has, bit last);
		bit took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {16'(weight), 4'(to_v), 4'(from_v)};
		s_tuser <= has;
		s_tlast <= last;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		edges_sent++;
	endtask

	task automatic quiet_and_idle();
		s_tvalid <= 0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		// the edge store is swept after the last result
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= sssp_pkg::CNT_W'(value);
		@(posedge clk);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	task automatic setup(int src, int cnt);
		quiet_and_idle();
		write_reg(sssp_pkg::CFG_SOURCE_VERTEX, src);
		write_reg(sssp_pkg::CFG_VERTEX_COUNT, cnt);
	endtask

	// random graph, endpoints mostly inside the vertices in use
	task automatic random_graph(int n_edges, int n);
		int f, t, w, pick;
		for (int i = 0; i < n_edges; i++) begin
			f = ($urandom_range(0, 99) < 90) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
			t = ($urandom_range(0, 99) < 90) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
			pick = $urandom_range(0, 99);
			if (pick < 70) w = $urandom_range(0, 48) - 8;
			else if (pick < 90) w = $urandom_range(0, 300);
			else w = $urandom;
			send_edge(f, t, w, $urandom_range(0, 9) != 0, i == n_edges - 1);
		end
	endtask

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: overwrite, extreme weights, no-edge item, unused endpoint
		setup(0, 4);
		send_edge(0, 1, 32767, 1, 0);
		send_edge(0, 1, 10, 1, 0);
		send_edge(1, 2, -32768, 1, 0);
		send_edge(2, 3, 100, 1, 0);
		send_edge(15, 15, 1234, 1, 0);
		send_edge(0, 3, 5, 0, 0);
		send_edge(1, 3, -5, 1, 1);
		// reachable negative cycle
		send_edge(0, 1, 4, 1, 0);
		send_edge(1, 2, -3, 1, 0);
		send_edge(2, 1, -3, 1, 1);
		// full size, highest source
		setup(15, 16);
		send_edge(15, 0, 1, 1, 0);
		send_edge(0, 14, -2, 1, 0);
		send_edge(14, 15, 2, 1, 1);
		// count zero clamps to one; negative self loop
		setup(0, 0);
		send_edge(0, 0, -1, 1, 1);
		// oversized count clamps to the maximum
		setup(9, 31);
		send_edge(9, 3, 7, 1, 1);
		// source outside the vertices in use
		setup(6, 5);
		send_edge(6, 0, 1, 1, 0);
		send_edge(0, 1, 2, 1, 1);

		// back-pressure: results held while the next graphs queue up
		setup(2, 5);
		random_graph(6, 5);
		hold_req <= 1;
		@(posedge clk);
		hold_req <= 0;
		random_graph(6, 5);
		random_graph(5, 5);

		// random phases with changing idle patterns
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 80 : 0;
			recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 34 : 0;
			for (int g = 0; g < 7; g++) begin
				n = (g == 3 && ph != 1) ? 16 : $urandom_range(2, 6);
				if (g % 2 == 0) setup($urandom_range(0, n - 1), n);
				random_graph($urandom_range(6, 12), n);
			end
		end

		quiet_and_idle();
		$display("%0d edge transactions over %0d graphs, %0d vertex results checked",
			edges_sent, graphs_run, results_seen);
		$display("covered overwrites, extreme weights, negative cycles, clamped counts");
		if (mismatches == 0 && results_due == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
